[src/ftre_pkg.sv]
package ftre_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int NAME_BYTES_DEF = 24;
   localparam int SECTOR_BYTES_DEF = 512;
   localparam int READ_LIMIT_DEF = 116;
   localparam int WRITE_LIMIT_DEF = 112;
   localparam logic [31:0] FIRST_FREE_RESET = 32'd2;

   localparam logic [2:0] OP_OPEN = 3'd0;
   localparam logic [2:0] OP_READ = 3'd1;
   localparam logic [2:0] OP_CREATE = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_ERR = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] name_low;
      logic [63:0] name_mid;
      logic [63:0] name_high;
      logic [7:0]  file_index;
      logic [31:0] byte_offset;
      logic [31:0] byte_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  found_index;
      logic [6:0]  granted_bytes;
      logic [31:0] file_size;
      logic [31:0] first_sector;
      logic [8:0]  sector_byte;
      logic [1:0]  sector_count;
      logic        merge_existing;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CMP,
      S_FETCH,
      S_CALC,
      S_OUT
   } state_type;

endpackage

[src/file_table_request_engine_top.sv]
// File table request engine. Each request (open, read, create, write) yields
// one response. Entries live in one synchronous RAM (name, start, size per
// entry, registered read). Create and bad requests go from accept straight
// to response. Read and write pass through accept, fetch, compute (with
// write back for a non-empty write) and response. Open walks the table one
// entry at a time (RAM read, then compare). A new request is taken once the
// previous response has left the output register. No clearing pass: entry
// contents are used only once created.
module file_table_request_engine_top #(
   parameter int ENTRIES = ftre_pkg::ENTRIES_DEF,
   parameter int NAME_BYTES = ftre_pkg::NAME_BYTES_DEF,
   parameter int SECTOR_BYTES = ftre_pkg::SECTOR_BYTES_DEF,
   parameter int READ_LIMIT = ftre_pkg::READ_LIMIT_DEF,
   parameter int WRITE_LIMIT = ftre_pkg::WRITE_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ftre_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ftre_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SB = $clog2(SECTOR_BYTES);

   typedef struct packed {
      logic [191:0] name;
      logic [31:0]  start;
      logic [31:0]  size;
   } entry_type;

   entry_type mem [ENTRIES];
   entry_type rd_ff;
   logic [IW-1:0] raddr;
   logic          wen;
   logic [IW-1:0] waddr;
   entry_type     wdata;

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   ftre_pkg::state_type state_ff, state_in;
   ftre_pkg::req_type req_ff, req_in;
   ftre_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   next_free_ff, next_free_in;
   logic [IW-1:0] scan_ff, scan_in;

   logic [191:0] probe;
   logic         match;
   logic         idx_ok;
   logic [31:0]  fsize, remain, n, ns, secs, endsec;
   logic [SB:0]  bsum;
   logic [SB-1:0] byte_pos;

   assign probe = {req_ff.name_high, req_ff.name_mid, req_ff.name_low};
   assign idx_ok = {24'd0, req_ff.file_index} < 32'(count_ff);

   // NUL-terminated compare over the name bytes
   always_comb begin
      logic done;
      done = 1'b0;
      match = 1'b1;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (!done) begin
            if (rd_ff.name[i*8 +: 8] != probe[i*8 +: 8]) begin
               match = 1'b0;
               done = 1'b1;
            end else if (probe[i*8 +: 8] == 8'd0) begin
               done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftre_pkg::S_IDLE;
         count_ff <= '0;
         next_free_ff <= ftre_pkg::FIRST_FREE_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         next_free_ff <= next_free_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      scan_ff <= scan_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      count_in = count_ff;
      next_free_in = next_free_ff;
      scan_in = scan_ff;
      raddr = scan_ff;
      wen = 1'b0;
      waddr = req_ff.file_index[IW-1:0];
      wdata = rd_ff;
      fsize = rd_ff.size;
      remain = fsize - req_ff.byte_offset;
      n = remain;
      ns = fsize + req_ff.byte_length;
      secs = 32'(ns >> SB) + {31'd0, ns[SB-1:0] != '0};
      endsec = rd_ff.start + secs;
      byte_pos = '0;
      bsum = '0;
      if (csr_valid) next_free_in = csr_data;
      case (state_ff)
         ftre_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               scan_in = '0;
               rsp_in = '0;
               case (req_data.operation)
                  ftre_pkg::OP_OPEN: begin
                     rsp_in.status = ftre_pkg::ST_NOT_FOUND;
                     state_in = ftre_pkg::S_SCAN;
                  end
                  ftre_pkg::OP_CREATE: begin
                     if (count_ff >= CW'(ENTRIES)) begin
                        rsp_in.status = ftre_pkg::ST_ERR;
                     end else begin
                        wen = 1'b1;
                        waddr = count_ff[IW-1:0];
                        wdata.name = {req_data.name_high, req_data.name_mid,
                                      req_data.name_low};
                        wdata.start = next_free_ff;
                        wdata.size = '0;
                        rsp_in.found_index = 4'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                     state_in = ftre_pkg::S_OUT;
                  end
                  ftre_pkg::OP_READ, ftre_pkg::OP_WRITE: state_in = ftre_pkg::S_FETCH;
                  default: begin
                     rsp_in.status = ftre_pkg::ST_ERR;
                     state_in = ftre_pkg::S_OUT;
                  end
               endcase
            end
         end
         ftre_pkg::S_SCAN: begin
            if ({1'b0, scan_ff} >= (IW+1)'(count_ff) || 32'(count_ff) == 0)
               state_in = ftre_pkg::S_OUT;
            else
               state_in = ftre_pkg::S_CMP;
         end
         ftre_pkg::S_CMP: begin
            if (match) begin
               rsp_in.status = ftre_pkg::ST_OK;
               rsp_in.found_index = 4'(scan_ff);
               rsp_in.file_size = rd_ff.size;
               state_in = ftre_pkg::S_OUT;
            end else if (32'(scan_ff) == ENTRIES - 1) begin
               state_in = ftre_pkg::S_OUT;
            end else begin
               scan_in = scan_ff + 1'b1;
               state_in = ftre_pkg::S_SCAN;
            end
         end
         ftre_pkg::S_FETCH: begin
            raddr = req_ff.file_index[IW-1:0];
            state_in = ftre_pkg::S_CALC;
         end
         ftre_pkg::S_CALC: begin
            state_in = ftre_pkg::S_OUT;
            if (!idx_ok) begin
               rsp_in.status = ftre_pkg::ST_ERR;
            end else if (req_ff.operation == ftre_pkg::OP_READ) begin
               if (req_ff.byte_offset < fsize) begin
                  if (n > req_ff.byte_length) n = req_ff.byte_length;
                  if (n > 32'(READ_LIMIT)) n = 32'(READ_LIMIT);
                  byte_pos = req_ff.byte_offset[SB-1:0];
                  bsum = {1'b0, byte_pos} + (SB+1)'(n);
                  rsp_in.granted_bytes = 7'(n);
                  rsp_in.file_size = fsize;
                  rsp_in.first_sector = rd_ff.start + 32'(req_ff.byte_offset >> SB);
                  rsp_in.sector_byte = 9'(byte_pos);
                  rsp_in.sector_count = (bsum > (SB+1)'(SECTOR_BYTES)) ? 2'd2 : 2'd1;
               end
            end else if (req_ff.byte_length > 32'(WRITE_LIMIT)) begin
               rsp_in.status = ftre_pkg::ST_ERR;
            end else if (req_ff.byte_length != 0) begin
               byte_pos = fsize[SB-1:0];
               bsum = {1'b0, byte_pos} + (SB+1)'(req_ff.byte_length);
               rsp_in.granted_bytes = 7'(req_ff.byte_length);
               rsp_in.first_sector = rd_ff.start + 32'(fsize >> SB);
               rsp_in.sector_byte = 9'(byte_pos);
               rsp_in.sector_count = (bsum > (SB+1)'(SECTOR_BYTES)) ? 2'd2 : 2'd1;
               rsp_in.merge_existing = byte_pos != '0;
               wen = 1'b1;
               wdata.size = ns;
               if (endsec > next_free_ff) next_free_in = endsec;
            end
         end
         ftre_pkg::S_OUT: begin
            if (!rsp_stall) state_in = ftre_pkg::S_IDLE;
         end
         default: state_in = ftre_pkg::S_IDLE;
      endcase
   end

   assign req_stall = state_ff != ftre_pkg::S_IDLE;
   assign rsp_valid = state_ff == ftre_pkg::S_OUT;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES)) else $error("entry count overflow");
   a_grow: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) && !$past(reset) |->
      req_ff.operation == ftre_pkg::OP_CREATE)
      else $error("count changed outside create");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response lost");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("accept while response pending");
`endif

endmodule
